[rtl/tcgr_pkg.sv]
`timescale 1ns / 1ps

package tcgr_pkg;

  // Screen and font limits.
  localparam int MaxColumns = 256;
  localparam int MaxRows    = 128;
  localparam int GlyphCount = 128;
  localparam int CellSize   = 8;

  // Derived widths.
  localparam int ColW     = $clog2(MaxColumns);        // cursor column
  localparam int RowW     = $clog2(MaxRows);           // cursor line
  localparam int ColsW    = ColW + 1;                  // column count, holds MaxColumns
  localparam int RowsW    = RowW + 1;                  // line count, holds MaxRows
  localparam int GlyphW   = $clog2(GlyphCount);
  localparam int CellW    = $clog2(CellSize);
  localparam int PixW     = 2 * CellW;                 // pixel index inside a cell
  localparam int StoreAw  = GlyphW + CellW;
  localparam int StoreDepth = GlyphCount * CellSize;
  localparam int AddrW    = 21;
  localparam int ColorW   = 32;
  localparam int CfgDataW = 32;
  localparam int CfgIdxW  = 2;

  // Stream widths.
  localparam int InDataW  = 48;
  localparam int InUserW  = 2;
  localparam int OutDataW = 56;
  localparam int OutUserW = 2;

  // Register reset values.
  localparam logic [ColsW-1:0]  ColsReset = ColsW'(80);
  localparam logic [RowsW-1:0]  RowsReset = RowsW'(25);
  localparam logic [ColorW-1:0] FgReset   = 32'h00FF_FFFF;
  localparam logic [ColorW-1:0] BgReset   = 32'h0000_0000;

  // Character codes.
  localparam logic [7:0] CharNewline = 8'd10;
  localparam logic [7:0] CharTab     = 8'd9;
  localparam logic [7:0] CharSpace   = 8'd32;
  localparam logic [8:0] DrawLimit   = 9'd128;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_COLUMNS = 2'd0,
    REG_ROWS    = 2'd1,
    REG_FG      = 2'd2,
    REG_BG      = 2'd3
  } reg_idx_e;

  // Input actions.
  typedef enum logic [1:0] {
    ACT_WRITE_CHAR = 2'd0,
    ACT_LOAD_ROW   = 2'd1,
    ACT_SET_CURSOR = 2'd2,
    ACT_NONE       = 2'd3
  } action_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SETUP  = 4'b0010,
    ST_DRAW   = 4'b0100,
    ST_SINGLE = 4'b1000
  } state_e;

  // Fields of one input beat.
  typedef struct packed {
    logic [RowW-1:0]   cursor_row;
    logic [ColW-1:0]   cursor_col;
    logic [7:0]        row_bits;
    logic [CellW-1:0]  glyph_row;
    logic [GlyphW-1:0] glyph_code;
    logic [7:0]        char_code;
    logic [1:0]        action;
  } in_item_t;

endpackage

[rtl/text_console_glyph_renderer_top.sv]
`timescale 1ns / 1ps

// Text console renderer with an 8x8 font. A drawn character (code below 128,
// tab drawn as space) produces 64 pixel-write beats, one per cycle when the
// output is not stalled, after a setup state that reads the first glyph row
// and forms the cell's base address. Newline and codes 128 and above give one
// beat with write_valid low; glyph loads and cursor moves give no beat. The
// pixel rate is set by the single pixel-address adder, which steps through
// the cell one pixel a cycle, and by the one read port of the glyph memory.
// The input is not ready while a character is being expanded. scroll_request
// comes only on the last beat of a character. The glyph memory has no reset;
// reading a glyph row that was never loaded gives undefined pixel colors.
module text_console_glyph_renderer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration writes.
  input  logic                           cfg_we_i,
  input  logic [tcgr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tcgr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // From bit 0: char_code[7:0], glyph_code[14:8], glyph_row[17:15],
  // row_bits[25:18], cursor_col[33:26], cursor_row[40:34], zero pad.
  input  logic [tcgr_pkg::InDataW-1:0]   s_axis_tdata,
  // From bit 0: action[1:0].
  input  logic [tcgr_pkg::InUserW-1:0]   s_axis_tuser,
  // Output stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // From bit 0: pixel_addr[20:0], pixel_color[52:21], zero pad.
  output logic [tcgr_pkg::OutDataW-1:0]  m_axis_tdata,
  // From bit 0: write_valid, scroll_request.
  output logic [tcgr_pkg::OutUserW-1:0]  m_axis_tuser,
  output logic                           m_axis_tlast
);

  localparam int ColsW  = tcgr_pkg::ColsW;
  localparam int RowsW  = tcgr_pkg::RowsW;
  localparam int ColW   = tcgr_pkg::ColW;
  localparam int RowW   = tcgr_pkg::RowW;
  localparam int GlyphW = tcgr_pkg::GlyphW;
  localparam int CellW  = tcgr_pkg::CellW;
  localparam int PixW   = tcgr_pkg::PixW;
  localparam int AddrW  = tcgr_pkg::AddrW;
  localparam int ColorW = tcgr_pkg::ColorW;

  // Configuration registers.
  logic [ColsW-1:0]  cols_q;
  logic [RowsW-1:0]  rows_q;
  logic [ColorW-1:0] fg_q;
  logic [ColorW-1:0] bg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= tcgr_pkg::ColsReset;
      rows_q <= tcgr_pkg::RowsReset;
      fg_q   <= tcgr_pkg::FgReset;
      bg_q   <= tcgr_pkg::BgReset;
    end else if (cfg_we_i) begin
      unique case (tcgr_pkg::reg_idx_e'(cfg_idx_i))
        tcgr_pkg::REG_COLUMNS: cols_q <= cfg_wdata_i[ColsW-1:0];
        tcgr_pkg::REG_ROWS:    rows_q <= cfg_wdata_i[RowsW-1:0];
        tcgr_pkg::REG_FG:      fg_q   <= cfg_wdata_i[ColorW-1:0];
        tcgr_pkg::REG_BG:      bg_q   <= cfg_wdata_i[ColorW-1:0];
        default: ;
      endcase
    end
  end

  // Effective screen size, clamped to the supported range.
  logic [ColsW-1:0] eff_cols;
  logic [RowsW-1:0] eff_rows;

  always_comb begin
    eff_cols = cols_q;
    if (cols_q == '0) begin
      eff_cols = ColsW'(1);
    end else if (cols_q > ColsW'(tcgr_pkg::MaxColumns)) begin
      eff_cols = ColsW'(tcgr_pkg::MaxColumns);
    end
    eff_rows = rows_q;
    if (rows_q == '0) begin
      eff_rows = RowsW'(1);
    end else if (rows_q > RowsW'(tcgr_pkg::MaxRows)) begin
      eff_rows = RowsW'(tcgr_pkg::MaxRows);
    end
  end

  // Input decode.
  tcgr_pkg::in_item_t in_item;
  tcgr_pkg::action_e  in_action;
  logic               in_fire;

  assign in_item   = tcgr_pkg::in_item_t'({
                       s_axis_tdata[$bits(tcgr_pkg::in_item_t)-tcgr_pkg::InUserW-1:0],
                       s_axis_tuser});
  assign in_action = tcgr_pkg::action_e'(in_item.action);
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  // Sequencer and working registers.
  tcgr_pkg::state_e  state_q, state_d;
  logic [ColW-1:0]   cur_col_q, cur_col_d;
  logic [RowW-1:0]   cur_line_q, cur_line_d;
  logic [ColW-1:0]   draw_col_q, draw_col_d;
  logic [RowW-1:0]   draw_line_q, draw_line_d;
  logic [GlyphW-1:0] glyph_q, glyph_d;
  logic              scroll_q, scroll_d;
  logic [PixW-1:0]   pix_q, pix_d;
  logic [AddrW-1:0]  addr_q, addr_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [AddrW-1:0]  out_addr_q, out_addr_d;
  logic [ColorW-1:0] out_color_q, out_color_d;
  logic              out_wv_q, out_wv_d;
  logic              out_scroll_q, out_scroll_d;
  logic              out_last_q, out_last_d;
  logic              out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  // Glyph memory: one write port, one registered read port.
  logic [7:0]                         glyph_mem [tcgr_pkg::StoreDepth];
  logic [7:0]                         row_data_q;
  logic [tcgr_pkg::StoreAw-1:0]       rd_addr;
  logic                               mem_we;

  assign mem_we = in_fire && (in_action == tcgr_pkg::ACT_LOAD_ROW) &&
                  ({1'b0, in_item.glyph_code} < (GlyphW + 1)'(tcgr_pkg::GlyphCount));
  // Reading the row of the next pixel keeps row_data_q on the current row.
  assign rd_addr = {glyph_q, pix_d[PixW-1:CellW]};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      glyph_mem[{in_item.glyph_code, in_item.glyph_row}] <= in_item.row_bits;
    end
    row_data_q <= glyph_mem[rd_addr];
  end

  // Character handling: cursor clamp, advance, wrap and scroll.
  logic [ColW-1:0]   col_c;
  logic [RowW-1:0]   line_c;
  logic [7:0]        glyph_ch;
  logic              is_newline;
  logic              do_draw;
  logic [ColsW-1:0]  col_n;
  logic [RowsW-1:0]  line_n;
  logic              scroll_n;

  always_comb begin
    col_c  = ({1'b0, cur_col_q} >= eff_cols) ? ColW'(eff_cols - ColsW'(1)) : cur_col_q;
    line_c = ({1'b0, cur_line_q} >= eff_rows) ? RowW'(eff_rows - RowsW'(1)) : cur_line_q;
    is_newline = (in_item.char_code == tcgr_pkg::CharNewline);
    glyph_ch   = (in_item.char_code == tcgr_pkg::CharTab) ? tcgr_pkg::CharSpace
                                                          : in_item.char_code;
    do_draw = !is_newline && ({1'b0, glyph_ch} < tcgr_pkg::DrawLimit) &&
              ({1'b0, glyph_ch} < 9'(tcgr_pkg::GlyphCount));
    if (is_newline) begin
      col_n  = '0;
      line_n = {1'b0, line_c} + RowsW'(1);
    end else begin
      col_n  = {1'b0, col_c} + ColsW'(1);
      line_n = {1'b0, line_c};
    end
    if (col_n >= eff_cols) begin
      col_n  = '0;
      line_n = {1'b0, line_c} + RowsW'(1);
    end
    scroll_n = 1'b0;
    if (line_n >= eff_rows) begin
      scroll_n = 1'b1;
      line_n   = eff_rows - RowsW'(1);
    end
  end

  // Cell base address and the step of the pixel address adder.
  logic [2*ColsW+RowW-1:0] line_prod;
  logic [AddrW-1:0]        base_addr;
  logic [AddrW-1:0]        addr_step;

  assign line_prod = (2*ColsW+RowW)'(draw_line_q) * (2*ColsW+RowW)'(eff_cols);
  assign base_addr = AddrW'(line_prod << (2 * CellW)) +
                     AddrW'({draw_col_q, CellW'(0)});
  // At the end of a glyph row jump to the start of the next pixel row.
  assign addr_step = (pix_q[CellW-1:0] == '1)
                   ? AddrW'({eff_cols, CellW'(0)}) - AddrW'(tcgr_pkg::CellSize - 1)
                   : AddrW'(1);

  always_comb begin
    state_d      = state_q;
    cur_col_d    = cur_col_q;
    cur_line_d   = cur_line_q;
    draw_col_d   = draw_col_q;
    draw_line_d  = draw_line_q;
    glyph_d      = glyph_q;
    scroll_d     = scroll_q;
    pix_d        = pix_q;
    addr_d       = addr_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_addr_d   = out_addr_q;
    out_color_d  = out_color_q;
    out_wv_d     = out_wv_q;
    out_scroll_d = out_scroll_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      tcgr_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (in_action)
            tcgr_pkg::ACT_WRITE_CHAR: begin
              cur_col_d   = ColW'(col_n);
              cur_line_d  = RowW'(line_n);
              draw_col_d  = col_c;
              draw_line_d = line_c;
              glyph_d     = glyph_ch[GlyphW-1:0];
              scroll_d    = scroll_n;
              pix_d       = '0;
              state_d     = do_draw ? tcgr_pkg::ST_SETUP : tcgr_pkg::ST_SINGLE;
            end
            tcgr_pkg::ACT_SET_CURSOR: begin
              cur_col_d  = ({1'b0, in_item.cursor_col} < eff_cols)
                         ? in_item.cursor_col : ColW'(eff_cols - ColsW'(1));
              cur_line_d = ({1'b0, in_item.cursor_row} < eff_rows)
                         ? in_item.cursor_row : RowW'(eff_rows - RowsW'(1));
            end
            default: ;
          endcase
        end
      end
      tcgr_pkg::ST_SETUP: begin
        // First glyph row is read this cycle; base address is formed.
        addr_d  = base_addr;
        state_d = tcgr_pkg::ST_DRAW;
      end
      tcgr_pkg::ST_DRAW: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_wv_d     = 1'b1;
          out_addr_d   = addr_q;
          out_color_d  = row_data_q[pix_q[CellW-1:0]] ? fg_q : bg_q;
          out_last_d   = (pix_q == '1);
          out_scroll_d = scroll_q && (pix_q == '1);
          addr_d       = addr_q + addr_step;
          pix_d        = pix_q + PixW'(1);
          if (pix_q == '1) begin
            state_d = tcgr_pkg::ST_IDLE;
          end
        end
      end
      tcgr_pkg::ST_SINGLE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_wv_d     = 1'b0;
          out_addr_d   = '0;
          out_color_d  = '0;
          out_last_d   = 1'b1;
          out_scroll_d = scroll_q;
          state_d      = tcgr_pkg::ST_IDLE;
        end
      end
      default: state_d = tcgr_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcgr_pkg::ST_IDLE;
      cur_col_q   <= '0;
      cur_line_q  <= '0;
      pix_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_col_q   <= cur_col_d;
      cur_line_q  <= cur_line_d;
      pix_q       <= pix_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    draw_col_q   <= draw_col_d;
    draw_line_q  <= draw_line_d;
    glyph_q      <= glyph_d;
    scroll_q     <= scroll_d;
    addr_q       <= addr_d;
    out_addr_q   <= out_addr_d;
    out_color_q  <= out_color_d;
    out_wv_q     <= out_wv_d;
    out_scroll_q <= out_scroll_d;
    out_last_q   <= out_last_d;
  end

  // Ports.
  assign s_axis_tready = (state_q == tcgr_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(tcgr_pkg::OutDataW - AddrW - ColorW)'(0), out_color_q, out_addr_q};
  assign m_axis_tuser  = {out_scroll_q, out_wv_q};
  assign m_axis_tlast  = out_last_q;

  // A scroll request only ever rides on the last beat of a character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("scroll request on a beat that is not the last");

  // A beat without a pixel write is a lone last beat with a cleared payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tlast && (m_axis_tdata == '0))
    else $error("non-write beat with payload or without last");

  // A drawn beat carries last exactly when it is the cell's final pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcgr_pkg::ST_DRAW) && out_free |=>
      m_axis_tvalid && (m_axis_tlast == ($past(pix_q) == '1)))
    else $error("last flag out of step with the pixel counter");

  // The input is never taken while a character is being expanded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcgr_pkg::ST_SETUP) || (state_q == tcgr_pkg::ST_DRAW) |-> !s_axis_tready)
    else $error("input ready during glyph expansion");

endmodule

[verif/tb_text_console_glyph_renderer_top.sv]
`timescale 1ns / 1ps

module tb_text_console_glyph_renderer_top;

  localparam int AddrW      = tcgr_pkg::AddrW;
  localparam int ColorW     = tcgr_pkg::ColorW;
  localparam int ColsW      = tcgr_pkg::ColsW;
  localparam int RowsW      = tcgr_pkg::RowsW;
  localparam int ColW       = tcgr_pkg::ColW;
  localparam int RowW       = tcgr_pkg::RowW;
  localparam int GlyphW     = tcgr_pkg::GlyphW;
  localparam int CellW      = tcgr_pkg::CellW;
  localparam int CellSize   = tcgr_pkg::CellSize;
  localparam int GlyphCount = tcgr_pkg::GlyphCount;
  localparam int MaxColumns = tcgr_pkg::MaxColumns;
  localparam int MaxRows    = tcgr_pkg::MaxRows;
  localparam int StoreDepth = tcgr_pkg::StoreDepth;
  localparam int InDataW    = tcgr_pkg::InDataW;
  localparam int InUserW    = tcgr_pkg::InUserW;
  localparam int OutDataW   = tcgr_pkg::OutDataW;
  localparam int OutUserW   = tcgr_pkg::OutUserW;
  localparam int CfgIdxW    = tcgr_pkg::CfgIdxW;
  localparam int CfgDataW   = tcgr_pkg::CfgDataW;

  typedef tcgr_pkg::in_item_t in_item_t;

  // One output beat, split into its fields.
  typedef struct packed {
    logic              write_valid;
    logic [AddrW-1:0]  addr;
    logic [ColorW-1:0] color;
    logic              scroll;
    logic              last;
  } pixel_beat_t;

  // One row of the directed table. Rows marked fixed carry their own expected beat.
  typedef struct {
    in_item_t    item;
    bit          fixed;
    pixel_beat_t beat;
  } stim_row_t;

  localparam pixel_beat_t NoDrawBeat       = '{1'b0, '0, '0, 1'b0, 1'b1};
  localparam pixel_beat_t NoDrawScrollBeat = '{1'b0, '0, '0, 1'b1, 1'b1};
  localparam int DrainCycles = 80;
  localparam int PhaseItems  = 42;

  logic                clk_i     = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                s_valid   = 1'b0;
  logic [InDataW-1:0]  s_data    = '0;
  logic [InUserW-1:0]  s_user    = '0;
  logic                s_ready;
  logic                m_valid;
  logic                m_ready   = 1'b0;
  logic [OutDataW-1:0] m_data;
  logic [OutUserW-1:0] m_user;
  logic                m_last;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned fail_count    = 0;

  // Shadow of the console: registers, cursor and font.
  logic [ColsW-1:0]  cols_reg    = tcgr_pkg::ColsReset;
  logic [RowsW-1:0]  rows_reg    = tcgr_pkg::RowsReset;
  logic [ColorW-1:0] ink_color   = tcgr_pkg::FgReset;
  logic [ColorW-1:0] paper_color = tcgr_pkg::BgReset;
  int unsigned       cur_col  = 0;
  int unsigned       cur_line = 0;
  logic [7:0]        font_rows  [StoreDepth];
  bit                row_loaded [StoreDepth];
  bit                glyph_full [GlyphCount];
  int unsigned       ready_glyphs [$];

  pixel_beat_t fresh_beats   [$];
  pixel_beat_t pending_beats [$];

  text_console_glyph_renderer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Works out the beats that one accepted item causes and updates the shadow state.
  task automatic render_item(input in_item_t it);
    int unsigned cols, rows, glyph, stride, slot, base_col, base_line;
    logic [7:0]  bits;
    bit          draw, scroll;
    pixel_beat_t b;
    fresh_beats.delete();
    cols = (cols_reg == '0) ? 1 : ((cols_reg > MaxColumns) ? MaxColumns : cols_reg);
    rows = (rows_reg == '0) ? 1 : ((rows_reg > MaxRows) ? MaxRows : rows_reg);
    case (tcgr_pkg::action_e'(it.action))
      tcgr_pkg::ACT_LOAD_ROW: begin
        if (it.glyph_code < GlyphCount) begin
          slot = it.glyph_code * CellSize + it.glyph_row;
          font_rows[slot]  = it.row_bits;
          row_loaded[slot] = 1'b1;
          if (!glyph_full[it.glyph_code]) begin
            glyph_full[it.glyph_code] = 1'b1;
            for (int r = 0; r < CellSize; r++) begin
              if (!row_loaded[it.glyph_code * CellSize + r]) glyph_full[it.glyph_code] = 1'b0;
            end
            if (glyph_full[it.glyph_code]) ready_glyphs.push_back(it.glyph_code);
          end
        end
      end
      tcgr_pkg::ACT_SET_CURSOR: begin
        cur_col  = (it.cursor_col < cols) ? it.cursor_col : cols - 1;
        cur_line = (it.cursor_row < rows) ? it.cursor_row : rows - 1;
      end
      tcgr_pkg::ACT_WRITE_CHAR: begin
        // A cursor left outside a shrunk screen is pulled back in first.
        if (cur_col >= cols) cur_col = cols - 1;
        if (cur_line >= rows) cur_line = rows - 1;
        glyph = (it.char_code == tcgr_pkg::CharTab) ? tcgr_pkg::CharSpace : it.char_code;
        draw  = (it.char_code != tcgr_pkg::CharNewline) && (glyph < tcgr_pkg::DrawLimit) &&
                (glyph < GlyphCount);
        base_col  = cur_col;
        base_line = cur_line;
        // Advance the cursor, wrap at the right edge, scroll past the bottom.
        if (it.char_code == tcgr_pkg::CharNewline) begin
          cur_col = 0;
          cur_line++;
        end else begin
          cur_col++;
        end
        if (cur_col >= cols) begin
          cur_col = 0;
          cur_line++;
        end
        scroll = 1'b0;
        if (cur_line >= rows) begin
          scroll   = 1'b1;
          cur_line = rows - 1;
        end
        if (draw) begin
          stride = cols * CellSize;
          for (int y = 0; y < CellSize; y++) begin
            bits = font_rows[glyph * CellSize + y];
            for (int x = 0; x < CellSize; x++) begin
              b.write_valid = 1'b1;
              b.addr  = AddrW'((x + base_col * CellSize) + (y + base_line * CellSize) * stride);
              b.color = bits[x] ? ink_color : paper_color;
              b.last  = (y == CellSize - 1) && (x == CellSize - 1);
              b.scroll = b.last ? scroll : 1'b0;
              fresh_beats.push_back(b);
            end
          end
        end else begin
          b = NoDrawBeat;
          b.scroll = scroll;
          fresh_beats.push_back(b);
        end
      end
      default: ;
    endcase
  endtask

  // Offers one item after a random gap and records what it should produce.
  task automatic send_item(input in_item_t it, input bit fixed, input pixel_beat_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= it.action;
    s_data  <= InDataW'(it[$bits(in_item_t)-1:InUserW]);
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    render_item(it);
    if (fixed) pending_beats.push_back(beat);
    else foreach (fresh_beats[i]) pending_beats.push_back(fresh_beats[i]);
  endtask

  // Writes all four registers on consecutive cycles.
  task automatic apply_screen(input logic [31:0] cols, rows, fg, bg);
    cfg_we    <= 1'b1;
    cfg_idx   <= tcgr_pkg::REG_COLUMNS;
    cfg_wdata <= cols;
    @(posedge clk_i);
    cfg_idx   <= tcgr_pkg::REG_ROWS;
    cfg_wdata <= rows;
    @(posedge clk_i);
    cfg_idx   <= tcgr_pkg::REG_FG;
    cfg_wdata <= fg;
    @(posedge clk_i);
    cfg_idx   <= tcgr_pkg::REG_BG;
    cfg_wdata <= bg;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cols_reg    = cols[ColsW-1:0];
    rows_reg    = rows[RowsW-1:0];
    ink_color   = fg;
    paper_color = bg;
  endtask

  // Stops offering items and waits until the block has gone quiet.
  task automatic settle();
    s_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic in_item_t random_item();
    logic [63:0] noise;
    in_item_t    it;
    noise = {$urandom, $urandom};
    it = noise[$bits(in_item_t)-1:0];
    return it;
  endfunction

  function automatic in_item_t char_item(input logic [7:0] code);
    in_item_t it;
    it = '0;
    it.action    = tcgr_pkg::ACT_WRITE_CHAR;
    it.char_code = code;
    return it;
  endfunction

  function automatic in_item_t load_item(input int unsigned g, r, input logic [7:0] bits);
    in_item_t it;
    it = '0;
    it.action     = tcgr_pkg::ACT_LOAD_ROW;
    it.glyph_code = g[GlyphW-1:0];
    it.glyph_row  = r[CellW-1:0];
    it.row_bits   = bits;
    return it;
  endfunction

  function automatic in_item_t cursor_item(input int unsigned c, l);
    in_item_t it;
    it = '0;
    it.action     = tcgr_pkg::ACT_SET_CURSOR;
    it.cursor_col = c[ColW-1:0];
    it.cursor_row = l[RowW-1:0];
    return it;
  endfunction

  // A character is safe to send when it draws nothing or its glyph is fully loaded.
  function automatic bit glyph_safe(input logic [7:0] code);
    if (code >= tcgr_pkg::DrawLimit || code == tcgr_pkg::CharNewline) return 1'b1;
    return glyph_full[(code == tcgr_pkg::CharTab) ? tcgr_pkg::CharSpace : code];
  endfunction

  // Random traffic: mostly whole glyph loads and printable text, plus noise.
  task automatic random_burst(input int unsigned count);
    int unsigned made, pick, sub, g;
    in_item_t    it;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      it = random_item();
      if (pick < 12) begin
        g = $urandom_range(GlyphCount - 1);
        for (int r = 0; r < CellSize; r++) begin
          it = random_item();
          it.action     = tcgr_pkg::ACT_LOAD_ROW;
          it.glyph_code = g[GlyphW-1:0];
          it.glyph_row  = r[CellW-1:0];
          send_item(it, 1'b0, '0);
        end
        made += CellSize;
      end else if (pick < 17) begin
        it.action = tcgr_pkg::ACT_LOAD_ROW;
        send_item(it, 1'b0, '0);
        made++;
      end else if (pick < 27) begin
        it.action = tcgr_pkg::ACT_SET_CURSOR;
        send_item(it, 1'b0, '0);
        made++;
      end else if (pick < 30) begin
        it.action = tcgr_pkg::ACT_NONE;
        send_item(it, 1'b0, '0);
        made++;
      end else begin
        it.action = tcgr_pkg::ACT_WRITE_CHAR;
        sub = $urandom_range(19);
        if (sub == 0) it.char_code = tcgr_pkg::CharNewline;
        else if (sub == 1) it.char_code = tcgr_pkg::CharTab;
        else if (sub < 5) it.char_code = 8'($urandom_range(255, 128));
        else if (sub < 9) it.char_code = 8'($urandom_range(255));
        else if (ready_glyphs.size() != 0)
          it.char_code = 8'(ready_glyphs[$urandom_range(ready_glyphs.size() - 1)]);
        if (!glyph_safe(it.char_code)) it.char_code[7] = 1'b1;
        send_item(it, 1'b0, '0);
        made++;
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // Compares each accepted output beat with the oldest expected one.
  task automatic check_beat();
    pixel_beat_t want, got;
    got.write_valid = m_user[0];
    got.scroll      = m_user[1];
    got.addr        = m_data[AddrW-1:0];
    got.color       = m_data[AddrW +: ColorW];
    got.last        = m_last;
    if (pending_beats.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected beat, expected none, actual %h", $time, got);
      return;
    end
    want = pending_beats.pop_front();
    check_field("write_valid", want.write_valid, got.write_valid);
    check_field("pixel_addr", want.addr, got.addr);
    check_field("pixel_color", want.color, got.color);
    check_field("scroll_request", want.scroll, got.scroll);
    check_field("last", want.last, got.last);
  endtask

  // Output side: random stalls and beat checking.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (m_valid && m_ready) check_beat();
      m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    stim_row_t directed_rows [$];
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed part, on the reset screen of 80 by 25 cells.
    directed_rows = '{
      '{char_item(tcgr_pkg::CharNewline), 1'b1, NoDrawBeat},
      '{char_item(8'd200), 1'b1, NoDrawBeat},
      '{char_item(8'd255), 1'b1, NoDrawBeat},
      '{in_item_t'('1), 1'b0, '0},
      '{load_item(tcgr_pkg::CharSpace, 0, 8'h00), 1'b0, '0},
      '{load_item(tcgr_pkg::CharSpace, 1, 8'hFF), 1'b0, '0},
      '{load_item(tcgr_pkg::CharSpace, 2, 8'h01), 1'b0, '0},
      '{load_item(tcgr_pkg::CharSpace, 3, 8'h80), 1'b0, '0},
      '{load_item(tcgr_pkg::CharSpace, 4, 8'hAA), 1'b0, '0},
      '{load_item(tcgr_pkg::CharSpace, 5, 8'h55), 1'b0, '0},
      '{load_item(tcgr_pkg::CharSpace, 6, 8'h0F), 1'b0, '0},
      '{load_item(tcgr_pkg::CharSpace, 7, 8'hF0), 1'b0, '0},
      '{char_item(tcgr_pkg::CharSpace), 1'b0, '0},
      '{char_item(tcgr_pkg::CharTab), 1'b0, '0},
      // Cursor far out of range lands in the bottom right cell.
      '{cursor_item(255, 127), 1'b0, '0},
      '{char_item(tcgr_pkg::CharSpace), 1'b0, '0},
      '{cursor_item(255, 127), 1'b0, '0},
      '{char_item(8'd128), 1'b1, NoDrawScrollBeat},
      '{char_item(tcgr_pkg::CharNewline), 1'b1, NoDrawScrollBeat},
      '{cursor_item(0, 0), 1'b0, '0},
      '{load_item(127, 7, 8'hFF), 1'b0, '0},
      '{cursor_item(5, 3), 1'b0, '0},
      '{char_item(tcgr_pkg::CharTab), 1'b0, '0}
    };
    send_idle_pct = 37;
    recv_idle_pct = 71;
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].beat);
    settle();

    // Random phases, each on its own screen setting.
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 71;
        recv_idle_pct = 37;
      end
      if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: apply_screen(32'd1, 32'd1, 32'hFFFF_FFFF, 32'h0000_0000);
        1: apply_screen(32'd256, 32'd128, 32'h0000_0000, 32'hFFFF_FFFF);
        2: apply_screen($urandom & ~32'h1FF, $urandom & ~32'hFF, $urandom, $urandom);
        3: apply_screen($urandom | 32'h1FF, $urandom | 32'hFF, $urandom, $urandom);
        4: apply_screen(32'd3, 32'd2, $urandom, $urandom);
        default: apply_screen(($urandom & ~32'h1FF) | $urandom_range(256, 1),
                              ($urandom & ~32'hFF) | $urandom_range(128, 1),
                              $urandom, $urandom);
      endcase
      random_burst(PhaseItems);
      settle();
    end

    if (fail_count == 0 && pending_beats.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(10_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
